>>> hw/rtl/vrs_pkg.sv
package vrs_pkg;

    // Action codes.
    localparam logic ACT_ROTATE = 1'b0;
    localparam logic ACT_SHIFT  = 1'b1;

    // Shift axis codes. The last code marks an invalid axis.
    localparam logic [1:0] AXIS_K   = 2'd0;
    localparam logic [1:0] AXIS_J   = 2'd1;
    localparam logic [1:0] AXIS_I   = 2'd2;
    localparam logic [1:0] AXIS_BAD = 2'd3;

    // Rotation permutation codes.
    localparam logic [1:0] PERM_IDENT = 2'd0;
    localparam logic [1:0] PERM_IJ    = 2'd1;
    localparam logic [1:0] PERM_IK    = 2'd2;
    localparam logic [1:0] PERM_JK    = 2'd3;

    // Low face planes (coordinate zero) along each axis.
    localparam logic [63:0] FACE_K_LO = 64'h1111_1111_1111_1111;
    localparam logic [63:0] FACE_J_LO = 64'h000F_000F_000F_000F;
    localparam logic [63:0] FACE_I_LO = 64'h0000_0000_0000_FFFF;

    // Mask of all voxels whose coordinate along the given axis equals coord.
    function automatic logic [63:0] face_plane(input logic [1:0] axis,
                                               input logic [1:0] coord);
        logic [63:0] plane;
        case (axis)
            AXIS_K:  plane = FACE_K_LO << coord;
            AXIS_J:  plane = FACE_J_LO << {coord, 2'b00};
            AXIS_I:  plane = FACE_I_LO << {coord, 4'b0000};
            default: plane = 64'd0;
        endcase
        return plane;
    endfunction

    // Source bit index {i, j, k} that feeds output voxel (i, j, k) for a permutation.
    function automatic logic [5:0] rot_src(input logic [1:0] perm,
                                           input logic [1:0] i,
                                           input logic [1:0] j,
                                           input logic [1:0] k);
        logic [1:0] si;
        logic [1:0] sj;
        logic [1:0] sk;
        si = i;
        sj = j;
        sk = k;
        case (perm)
            PERM_IJ: begin
                si = 2'd3 - j;
                sj = i;
            end
            PERM_IK: begin
                si = 2'd3 - k;
                sk = i;
            end
            PERM_JK: begin
                sj = k;
                sk = 2'd3 - j;
            end
            default: begin
                si = i;
            end
        endcase
        return {si, sj, sk};
    endfunction

endpackage

>>> hw/rtl/vrs_rotate.sv
module vrs_rotate (
    input  logic [63:0] voxels_in,
    input  logic [1:0]  perm,
    output logic [63:0] voxels_out
);

    // Every output voxel picks one of four source bits, selected by the permutation.
    always_comb begin
        for (int n = 0; n < 64; n++) begin
            voxels_out[n] = voxels_in[vrs_pkg::rot_src(perm, 2'(n >> 4), 2'(n >> 2), 2'(n))];
        end
    end

endmodule

>>> hw/rtl/vrs_shift.sv
module vrs_shift (
    input  logic              [63:0] voxels_in,
    input  logic              [1:0]  axis,
    input  logic signed       [2:0]  amount,
    output logic              [63:0] voxels_out,
    output logic                     ok
);

    logic        neg;
    logic [2:0]  mag;
    logic [6:0]  shift_amt;
    logic [63:0] lost;
    logic [63:0] shifted;
    logic        axis_valid;

    // Direction and magnitude; the magnitude reaches four for the most negative count.
    assign neg = amount[2];
    assign mag = neg ? (3'd0 - 3'(amount)) : 3'(amount);

    // Bit distance of the move: the cell count times the axis stride.
    always_comb begin
        case (axis)
            vrs_pkg::AXIS_K: shift_amt = {4'b0000, mag};
            vrs_pkg::AXIS_J: shift_amt = {2'b00, mag, 2'b00};
            vrs_pkg::AXIS_I: shift_amt = {mag, 4'b0000};
            default:         shift_amt = 7'd0;
        endcase
    end

    // Planes whose voxels would be pushed through the leading face.
    always_comb begin
        lost = 64'd0;
        for (int c = 0; c < 4; c++) begin
            if (neg) begin
                if (3'(c) < mag) begin
                    lost = lost | vrs_pkg::face_plane(axis, 2'(c));
                end
            end else begin
                if (({2'b00, 2'(c)} + {1'b0, mag}) >= 4'd4) begin
                    lost = lost | vrs_pkg::face_plane(axis, 2'(c));
                end
            end
        end
    end

    // The move itself; no set voxel wraps into a neighbor row when nothing is lost.
    assign shifted    = neg ? (voxels_in >> shift_amt) : (voxels_in << shift_amt);
    assign axis_valid = (axis != vrs_pkg::AXIS_BAD);
    assign ok         = axis_valid && ((voxels_in & lost) == 64'd0);
    assign voxels_out = ok ? shifted : 64'd0;

endmodule

>>> hw/rtl/voxel_rotate_shift_unit.sv
// Voxel rotate/shift unit for the 64-bit occupancy mask of a 4x4x4 cube, where
// voxel (i,j,k) is bit i*16+j*4+k. With action rotate the mask goes through one
// of four fixed permutations and ok is always one. With action shift the mask is
// moved along k, j or i by the signed amount; if any set voxel would leave the
// cube, or the axis code is invalid, the result is a zero mask with ok zero.
// The unit takes one transaction per clock cycle while m_ready does not hold back
// the output: an input register feeds the rotate and shift logic, whose result
// lands in an output register before it appears on the m_ side. While a result
// waits for m_ready, the next input is still taken into the input register if
// that register is empty.
module voxel_rotate_shift_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic        [63:0] s_voxels_in,
    input  logic        [1:0]  s_axis,
    input  logic signed [2:0]  s_amount,
    output logic               m_valid,
    input  logic               m_ready,
    output logic        [63:0] m_voxels_out,
    output logic               m_ok
);

    logic               in_valid_reg;
    logic               in_action_reg;
    logic        [63:0] in_voxels_reg;
    logic        [1:0]  in_axis_reg;
    logic signed [2:0]  in_amount_reg;
    logic               out_valid_reg;
    logic        [63:0] out_voxels_reg;
    logic               out_ok_reg;

    logic               out_free;
    logic               in_free;
    logic [63:0]        rot_voxels;
    logic [63:0]        shift_voxels;
    logic               shift_ok;
    logic [63:0]        out_voxels_next;
    logic               out_ok_next;

    // Pipeline flow control: each stage moves when the stage after it has room.
    assign out_free = !out_valid_reg || m_ready;
    assign in_free  = !in_valid_reg || out_free;
    assign s_ready  = in_free;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_free) begin
            in_valid_reg <= s_valid;
        end
        if (in_free && s_valid) begin
            in_action_reg <= s_action;
            in_voxels_reg <= s_voxels_in;
            in_axis_reg   <= s_axis;
            in_amount_reg <= s_amount;
        end
    end

    vrs_rotate u_rotate (
        .voxels_in  (in_voxels_reg),
        .perm       (in_axis_reg),
        .voxels_out (rot_voxels)
    );

    vrs_shift u_shift (
        .voxels_in  (in_voxels_reg),
        .axis       (in_axis_reg),
        .amount     (in_amount_reg),
        .voxels_out (shift_voxels),
        .ok         (shift_ok)
    );

    // Pick the result of the requested action.
    always_comb begin
        case (in_action_reg)
            vrs_pkg::ACT_ROTATE: begin
                out_voxels_next = rot_voxels;
                out_ok_next     = 1'b1;
            end
            default: begin
                out_voxels_next = shift_voxels;
                out_ok_next     = shift_ok;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
        if (out_free && in_valid_reg) begin
            out_voxels_reg <= out_voxels_next;
            out_ok_reg     <= out_ok_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_voxels_out = out_voxels_reg;
    assign m_ok         = out_ok_reg;

endmodule

>>> verif/voxel_rotate_shift_unit_tb.sv
module voxel_rotate_shift_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // High face planes (coordinate three) along k, j and i.
    localparam logic [63:0] K_TOP_FACE = 64'h8888_8888_8888_8888;
    localparam logic [63:0] J_TOP_FACE = 64'hF000_F000_F000_F000;
    localparam logic [63:0] I_TOP_FACE = 64'hFFFF_0000_0000_0000;

    localparam int RANDOM_MOVES = 900;

    typedef struct {
        logic              act;
        logic       [63:0] vox;
        logic       [1:0]  ax;
        logic signed [2:0] amt;
        int                gap;
        bit                hold_first;
    } voxel_move_t;

    typedef struct {
        logic [63:0] mask;
        logic        ok;
    } voxel_result_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_action = vrs_pkg::ACT_ROTATE;
    logic       [63:0] s_voxels_in = '0;
    logic       [1:0]  s_axis = vrs_pkg::AXIS_K;
    logic signed [2:0] s_amount = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic       [63:0] m_voxels_out;
    logic              m_ok;

    voxel_move_t   pending_moves[$];
    voxel_result_t expected_results[$];

    int moves_planned = 0;
    int moves_accepted = 0;
    int rotates_sent = 0;
    int shifts_sent = 0;
    int results_checked = 0;
    int refused_seen = 0;
    int mismatch_count = 0;
    int send_wait = 0;
    int recv_wait = 0;

    voxel_rotate_shift_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_voxels_in  (s_voxels_in),
        .s_axis       (s_axis),
        .s_amount     (s_amount),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_voxels_out (m_voxels_out),
        .m_ok         (m_ok)
    );

    // Expected mask and ok flag for one rotate or shift.
    function automatic voxel_result_t predict_move(input logic act,
                                                   input logic [63:0] vox,
                                                   input logic [1:0] ax,
                                                   input logic signed [2:0] amt);
        voxel_result_t r;
        logic [63:0]   wall;
        int            i, j, k, si, sj, sk, n, steps, span;
        r.mask = '0;
        r.ok   = 1'b1;
        if (act == vrs_pkg::ACT_ROTATE) begin
            for (i = 0; i < 4; i++) begin
                for (j = 0; j < 4; j++) begin
                    for (k = 0; k < 4; k++) begin
                        si = i;
                        sj = j;
                        sk = k;
                        case (ax)
                            vrs_pkg::PERM_IJ: begin
                                si = 3 - j;
                                sj = i;
                            end
                            vrs_pkg::PERM_IK: begin
                                si = 3 - k;
                                sk = i;
                            end
                            vrs_pkg::PERM_JK: begin
                                sj = k;
                                sk = 3 - j;
                            end
                            default: begin
                            end
                        endcase
                        r.mask[i * 16 + j * 4 + k] = vox[si * 16 + sj * 4 + sk];
                    end
                end
            end
        end else if (ax == vrs_pkg::AXIS_BAD) begin
            r.ok = 1'b0;
        end else begin
            // Step one cell at a time; a set voxel on the leading face refuses the move.
            steps = (amt < 0) ? -int'(amt) : int'(amt);
            case (ax)
                vrs_pkg::AXIS_K: begin
                    span = 1;
                    wall = (amt < 0) ? vrs_pkg::FACE_K_LO : K_TOP_FACE;
                end
                vrs_pkg::AXIS_J: begin
                    span = 4;
                    wall = (amt < 0) ? vrs_pkg::FACE_J_LO : J_TOP_FACE;
                end
                default: begin
                    span = 16;
                    wall = (amt < 0) ? vrs_pkg::FACE_I_LO : I_TOP_FACE;
                end
            endcase
            r.mask = vox;
            for (n = 0; n < steps; n++) begin
                if ((r.mask & wall) != '0) begin
                    r.ok = 1'b0;
                    break;
                end
                r.mask = (amt < 0) ? (r.mask >> span) : (r.mask << span);
            end
            if (!r.ok) begin
                r.mask = '0;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic add_move(input logic act, input logic [63:0] vox, input logic [1:0] ax,
                            input int amt, input bit calm, input bit hold);
        voxel_move_t mv;
        mv.act        = act;
        mv.vox        = vox;
        mv.ax         = ax;
        mv.amt        = 3'(amt);
        mv.gap        = calm ? 0 : $urandom_range(6, 0);
        mv.hold_first = hold;
        pending_moves = {pending_moves, mv};
        moves_planned++;
    endtask

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Driver: presents queued moves and records the expected result of each transaction.
    always @(posedge aclk) begin : drive_moves
        voxel_move_t   mv;
        voxel_result_t exp_r;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            send_wait <= 0;
        end else begin
            if (s_valid && s_ready) begin
                exp_r = predict_move(s_action, s_voxels_in, s_axis, s_amount);
                expected_results = {expected_results, exp_r};
                moves_accepted++;
                if (s_action == vrs_pkg::ACT_ROTATE) begin
                    rotates_sent++;
                end else begin
                    shifts_sent++;
                end
            end
            if (!(s_valid && !s_ready)) begin
                if (send_wait != 0) begin
                    send_wait <= send_wait - 1;
                    s_valid   <= 1'b0;
                end else if (pending_moves.size() != 0 &&
                             !(pending_moves[0].hold_first && expected_results.size() != 0)) begin
                    mv = pending_moves.pop_front();
                    s_action    <= mv.act;
                    s_voxels_in <= mv.vox;
                    s_axis      <= mv.ax;
                    s_amount    <= mv.amt;
                    s_valid     <= 1'b1;
                    send_wait   <= mv.gap;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transaction against the oldest expectation.
    always @(posedge aclk) begin : check_results
        voxel_result_t want;
        int            stall;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_wait <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %h ok=%b with nothing outstanding",
                                              m_voxels_out, m_ok));
                end else begin
                    want = expected_results.pop_front();
                    if (m_voxels_out !== want.mask) begin
                        report_mismatch($sformatf("voxels_out %h, expected %h",
                                                  m_voxels_out, want.mask));
                    end
                    if (m_ok !== want.ok) begin
                        report_mismatch($sformatf("ok %b, expected %b", m_ok, want.ok));
                    end
                end
                results_checked++;
                if (m_ok !== 1'b1) begin
                    refused_seen++;
                end
                // Every fourth stretch of results runs without back-pressure.
                stall = ((results_checked / 150) % 4 == 2) ? 0 : $urandom_range(6, 0);
                if (stall == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready   <= 1'b0;
                    recv_wait <= stall - 1;
                end
            end else if (recv_wait != 0) begin
                recv_wait <= recv_wait - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Stimulus and end of run.
    initial begin : stimulus
        logic [63:0] pattern;
        logic [63:0] piece;
        int          n, c, kind;
        int          lo_i, hi_i, lo_j, hi_j, lo_k, hi_k;
        bit          calm;
        pattern = 64'h0123_4567_89AB_CDEF;

        // Directed moves: every permutation, face limits and the special amounts.
        add_move(vrs_pkg::ACT_ROTATE, pattern, vrs_pkg::PERM_IDENT, 0, 0, 0);
        add_move(vrs_pkg::ACT_ROTATE, pattern, vrs_pkg::PERM_IJ, 1, 0, 0);
        add_move(vrs_pkg::ACT_ROTATE, pattern, vrs_pkg::PERM_IK, 2, 0, 0);
        add_move(vrs_pkg::ACT_ROTATE, pattern, vrs_pkg::PERM_JK, 3, 0, 0);
        add_move(vrs_pkg::ACT_ROTATE, 64'h1, vrs_pkg::PERM_IJ, -4, 0, 0);
        add_move(vrs_pkg::ACT_ROTATE, 64'h1, vrs_pkg::PERM_IK, -1, 0, 0);
        add_move(vrs_pkg::ACT_ROTATE, 64'h1, vrs_pkg::PERM_JK, -2, 0, 0);
        add_move(vrs_pkg::ACT_ROTATE, '1, vrs_pkg::PERM_IJ, 3, 0, 0);
        add_move(vrs_pkg::ACT_SHIFT, pattern, vrs_pkg::AXIS_K, 0, 0, 0);
        add_move(vrs_pkg::ACT_SHIFT, '1, vrs_pkg::AXIS_J, 0, 0, 0);
        add_move(vrs_pkg::ACT_SHIFT, 64'h1, vrs_pkg::AXIS_BAD, 0, 0, 0);
        add_move(vrs_pkg::ACT_SHIFT, '1, vrs_pkg::AXIS_BAD, -4, 0, 0);
        add_move(vrs_pkg::ACT_SHIFT, '0, vrs_pkg::AXIS_I, -4, 0, 0);
        add_move(vrs_pkg::ACT_SHIFT, 64'h1, vrs_pkg::AXIS_K, -4, 0, 0);
        add_move(vrs_pkg::ACT_SHIFT, 64'h1, vrs_pkg::AXIS_K, 3, 0, 0);
        add_move(vrs_pkg::ACT_SHIFT, 64'h2, vrs_pkg::AXIS_K, 3, 0, 0);
        add_move(vrs_pkg::ACT_SHIFT, 64'hF000, vrs_pkg::AXIS_J, -3, 0, 0);
        add_move(vrs_pkg::ACT_SHIFT, 64'h0F00, vrs_pkg::AXIS_J, 2, 0, 0);
        add_move(vrs_pkg::ACT_SHIFT, 64'hFFFF, vrs_pkg::AXIS_I, 3, 0, 0);
        add_move(vrs_pkg::ACT_SHIFT, '1, vrs_pkg::AXIS_I, -1, 0, 0);
        add_move(vrs_pkg::ACT_SHIFT, '0, vrs_pkg::AXIS_I, 2, 0, 0);
        add_move(vrs_pkg::ACT_SHIFT, 64'h7777_7777_7777_7777, vrs_pkg::AXIS_K, 1, 0, 0);

        // Random moves: mostly small pieces that fit the cube, plus full-noise masks.
        for (n = 0; n < RANDOM_MOVES; n++) begin
            calm = ((n / 100) % 4 == 1);
            lo_i = $urandom_range(3, 0);
            hi_i = $urandom_range(3, lo_i);
            lo_j = $urandom_range(3, 0);
            hi_j = $urandom_range(3, lo_j);
            lo_k = $urandom_range(3, 0);
            hi_k = $urandom_range(3, lo_k);
            piece = '0;
            for (c = 0; c < 64; c++) begin
                if (c / 16 >= lo_i && c / 16 <= hi_i && (c / 4) % 4 >= lo_j &&
                    (c / 4) % 4 <= hi_j && c % 4 >= lo_k && c % 4 <= hi_k &&
                    $urandom_range(2, 0) != 0) begin
                    piece[c] = 1'b1;
                end
            end
            kind = $urandom_range(9, 0);
            if (kind < 3) begin
                add_move(vrs_pkg::ACT_ROTATE, (kind == 0) ? {$urandom, $urandom} : piece,
                         2'($urandom_range(3, 0)), $urandom_range(7, 0), calm, n % 150 == 0);
            end else if (kind < 8) begin
                add_move(vrs_pkg::ACT_SHIFT, piece, 2'($urandom_range(2, 0)),
                         $urandom_range(7, 0), calm, n % 150 == 0);
            end else begin
                add_move(vrs_pkg::ACT_SHIFT, (kind == 8) ? {$urandom, $urandom} : piece,
                         2'($urandom_range(3, 0)), $urandom_range(7, 0), calm, n % 150 == 0);
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (moves_accepted < moves_planned) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Sent %0d rotate and %0d shift transactions, checked %0d results.",
                 rotates_sent, shifts_sent, results_checked);
        $display("%0d results were refused moves; %0d mismatches counted.",
                 refused_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #400000;
        $display("Run timed out with %0d results outstanding.", expected_results.size());
        $display("FAILURE");
        $finish;
    end

endmodule
